[rtl/core/tfdt_pkg.sv]
// shared types and constants of the triangle fragment depth test
`timescale 1ns / 1ps

package tfdt_pkg;

  // configuration register indexes
  localparam logic [2:0] REG_VERTEX0       = 3'd0;
  localparam logic [2:0] REG_VERTEX1       = 3'd1;
  localparam logic [2:0] REG_VERTEX2       = 3'd2;
  localparam logic [2:0] REG_SCREEN_WIDTH  = 3'd3;
  localparam logic [2:0] REG_SCREEN_HEIGHT = 3'd4;

  // port and field widths
  localparam int CFG_IDX_W   = 3;
  localparam int VERT_W      = 48;
  localparam int SCREEN_W    = 9;
  localparam int COORD_W     = 12;
  localparam int WEIGHT_W    = 17;
  localparam int WEIGHT_FRAC = 15;
  localparam int DEPTH_OUT_W = 16;
  localparam int S_TDATA_W   = 24;
  localparam int M_TDATA_W   = 56;
  localparam int M_TUSER_W   = 3;

  // datapath widths
  localparam int EDGE_W  = 40;
  localparam int NUM_W   = 56;
  localparam int DIV_W   = 36;
  localparam int MUL_A_W = 37;
  localparam int MUL_B_W = 18;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int CNT_W   = 6;

  // multiplier passes per pixel
  localparam int EDGE_STEPS  = 6;
  localparam int DEPTH_STEPS = 3;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CHECK,
    ST_EMUL,
    ST_SIGN,
    ST_AREA,
    ST_DIV_SET,
    ST_DIV_RUN,
    ST_DIV_END,
    ST_DMUL,
    ST_TEST,
    ST_DONE
  } state_t;

  // product selection, also names the accumulation target
  typedef enum logic [3:0] {
    MUL_D_P,
    MUL_D_N,
    MUL_NB_P,
    MUL_NB_N,
    MUL_NG_P,
    MUL_NG_N,
    MUL_Z0,
    MUL_Z1,
    MUL_Z2
  } mul_sel_t;

  typedef enum logic [1:0] {
    DIV_BETA,
    DIV_GAMMA,
    DIV_DEPTH
  } div_sel_t;

  typedef struct packed {
    logic     load;
    logic     clr_step;
    logic     mem_rd;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     acc_en;
    mul_sel_t acc_sel;
    logic     fix_sign;
    logic     calc_na;
    logic     div_start;
    logic     div_step;
    logic     div_store;
    div_sel_t div_sel;
    logic     depth_test;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic clear_done;
    logic on_screen;
    logic d_zero;
    logic in_tri;
    logic out_free;
  } status_t;

  // quotient bits of the shared divider
  function automatic int quo_bits(input int depth_bits);
    return (depth_bits > WEIGHT_W) ? depth_bits : WEIGHT_W;
  endfunction

endpackage

[rtl/core/triangle_fragment_depth_test.sv]
// top level of the triangle fragment depth test
`timescale 1ns / 1ps

// Tests one bounding-box pixel per input transfer against the configured
// triangle and updates the depth store when the interpolated depth is greater.
// After reset the store is swept to the most negative depth, one entry per
// cycle over all MAX_WIDTH*MAX_HEIGHT entries (65536 at the defaults); no pixel
// is taken until that ends, while configuration writes go through at once. One
// pixel is in work at a time: an off-screen pixel or a zero-area triangle ends
// early, a pixel outside the triangle takes the two weight divisions and one
// inside also the depth products and the depth division. The shared serial
// divider produces QB = max(17, DEPTH_BITS) quotient bits, one per cycle.
// One multiplier is shared by all products. A finished result waits in the
// output register while the next pixel is taken.
module triangle_fragment_depth_test #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int DEPTH_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [tfdt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tfdt_pkg::VERT_W-1:0]    cfg_data,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // pixel_x [11:0], pixel_y [23:12]
  input  logic [tfdt_pkg::S_TDATA_W-1:0] s_tdata,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // depth [15:0], weight_beta [32:16], weight_gamma [49:33], zero fill above
  output logic [tfdt_pkg::M_TDATA_W-1:0] m_tdata,
  // on_screen [0], inside_res [1], depth_written [2]
  output logic [tfdt_pkg::M_TUSER_W-1:0] m_tuser
);

  tfdt_pkg::cmd_t    cmd;
  tfdt_pkg::status_t status;

  // sequencer
  tfdt_ctrl #(
    .DEPTH_BITS (DEPTH_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // datapath and depth store
  tfdt_dpath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .DEPTH_BITS (DEPTH_BITS)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

endmodule

[rtl/core/tfdt_ctrl.sv]
// sequencer of the fragment depth test
`timescale 1ns / 1ps

module tfdt_ctrl #(
  parameter int DEPTH_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  tfdt_pkg::status_t status,
  output tfdt_pkg::cmd_t    cmd
);

  localparam int QB = tfdt_pkg::quo_bits(DEPTH_BITS);

  tfdt_pkg::state_t   state, state_next;
  tfdt_pkg::div_sel_t dsel, dsel_next;
  logic [tfdt_pkg::CNT_W-1:0] cnt, cnt_next, cnt_m1;

  assign cnt_m1 = cnt - 1'b1;

  function automatic tfdt_pkg::mul_sel_t edge_sel(input logic [2:0] c);
    case (c)
      3'd0:    return tfdt_pkg::MUL_D_P;
      3'd1:    return tfdt_pkg::MUL_D_N;
      3'd2:    return tfdt_pkg::MUL_NB_P;
      3'd3:    return tfdt_pkg::MUL_NB_N;
      3'd4:    return tfdt_pkg::MUL_NG_P;
      3'd5:    return tfdt_pkg::MUL_NG_N;
      default: return tfdt_pkg::MUL_D_P;
    endcase
  endfunction

  function automatic tfdt_pkg::mul_sel_t z_sel(input logic [1:0] c);
    case (c)
      2'd0:    return tfdt_pkg::MUL_Z0;
      2'd1:    return tfdt_pkg::MUL_Z1;
      default: return tfdt_pkg::MUL_Z2;
    endcase
  endfunction

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tfdt_pkg::ST_CLEAR;
      dsel  <= tfdt_pkg::DIV_BETA;
      cnt   <= '0;
    end else begin
      state <= state_next;
      dsel  <= dsel_next;
      cnt   <= cnt_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    dsel_next  = dsel;
    cnt_next   = cnt;
    case (state)
      tfdt_pkg::ST_CLEAR: begin
        if (status.clear_done) state_next = tfdt_pkg::ST_IDLE;
      end
      tfdt_pkg::ST_IDLE: begin
        if (s_tvalid) state_next = tfdt_pkg::ST_CHECK;
      end
      tfdt_pkg::ST_CHECK: begin
        cnt_next   = '0;
        state_next = status.on_screen ? tfdt_pkg::ST_EMUL : tfdt_pkg::ST_DONE;
      end
      tfdt_pkg::ST_EMUL: begin
        if (cnt == tfdt_pkg::CNT_W'(tfdt_pkg::EDGE_STEPS)) begin
          state_next = tfdt_pkg::ST_SIGN;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      tfdt_pkg::ST_SIGN: begin
        state_next = status.d_zero ? tfdt_pkg::ST_DONE : tfdt_pkg::ST_AREA;
      end
      tfdt_pkg::ST_AREA: begin
        dsel_next  = tfdt_pkg::DIV_BETA;
        state_next = tfdt_pkg::ST_DIV_SET;
      end
      tfdt_pkg::ST_DIV_SET: begin
        cnt_next   = '0;
        state_next = tfdt_pkg::ST_DIV_RUN;
      end
      tfdt_pkg::ST_DIV_RUN: begin
        if (cnt == tfdt_pkg::CNT_W'(QB - 1)) begin
          state_next = tfdt_pkg::ST_DIV_END;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      tfdt_pkg::ST_DIV_END: begin
        case (dsel)
          tfdt_pkg::DIV_BETA: begin
            dsel_next  = tfdt_pkg::DIV_GAMMA;
            state_next = tfdt_pkg::ST_DIV_SET;
          end
          tfdt_pkg::DIV_GAMMA: begin
            cnt_next   = '0;
            state_next = status.in_tri ? tfdt_pkg::ST_DMUL : tfdt_pkg::ST_DONE;
          end
          tfdt_pkg::DIV_DEPTH: state_next = tfdt_pkg::ST_TEST;
          default:             state_next = tfdt_pkg::ST_DONE;
        endcase
      end
      tfdt_pkg::ST_DMUL: begin
        if (cnt == tfdt_pkg::CNT_W'(tfdt_pkg::DEPTH_STEPS)) begin
          dsel_next  = tfdt_pkg::DIV_DEPTH;
          state_next = tfdt_pkg::ST_DIV_SET;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      tfdt_pkg::ST_TEST: state_next = tfdt_pkg::ST_DONE;
      tfdt_pkg::ST_DONE: begin
        if (status.out_free) state_next = tfdt_pkg::ST_IDLE;
      end
      default: state_next = tfdt_pkg::ST_IDLE;
    endcase
  end

  // commands to the datapath
  always_comb begin
    cmd         = '0;
    cmd.div_sel = dsel;
    s_tready    = 1'b0;
    case (state)
      tfdt_pkg::ST_CLEAR: cmd.clr_step = 1'b1;
      tfdt_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        cmd.load = s_tvalid;
      end
      tfdt_pkg::ST_CHECK: cmd.mem_rd = 1'b1;
      tfdt_pkg::ST_EMUL: begin
        cmd.mul_en  = (cnt < tfdt_pkg::CNT_W'(tfdt_pkg::EDGE_STEPS));
        cmd.mul_sel = edge_sel(cnt[2:0]);
        cmd.acc_en  = (cnt != '0);
        cmd.acc_sel = edge_sel(cnt_m1[2:0]);
      end
      tfdt_pkg::ST_SIGN:    cmd.fix_sign = ~status.d_zero;
      tfdt_pkg::ST_AREA:    cmd.calc_na = 1'b1;
      tfdt_pkg::ST_DIV_SET: cmd.div_start = 1'b1;
      tfdt_pkg::ST_DIV_RUN: cmd.div_step = 1'b1;
      tfdt_pkg::ST_DIV_END: cmd.div_store = 1'b1;
      tfdt_pkg::ST_DMUL: begin
        cmd.mul_en  = (cnt < tfdt_pkg::CNT_W'(tfdt_pkg::DEPTH_STEPS));
        cmd.mul_sel = z_sel(cnt[1:0]);
        cmd.acc_en  = (cnt != '0);
        cmd.acc_sel = z_sel(cnt_m1[1:0]);
      end
      tfdt_pkg::ST_TEST: cmd.depth_test = 1'b1;
      tfdt_pkg::ST_DONE: cmd.out_load = status.out_free;
      default: ;
    endcase
  end

endmodule

[rtl/core/tfdt_dpath.sv]
// datapath: registers, shared multiplier, serial divider and depth store
`timescale 1ns / 1ps

module tfdt_dpath #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int DEPTH_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  tfdt_pkg::cmd_t                      cmd,
  output tfdt_pkg::status_t                   status,
  input  logic                                cfg_we,
  input  logic [tfdt_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tfdt_pkg::VERT_W-1:0]         cfg_data,
  input  logic [tfdt_pkg::S_TDATA_W-1:0]      s_tdata,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [tfdt_pkg::M_TDATA_W-1:0]      m_tdata,
  output logic [tfdt_pkg::M_TUSER_W-1:0]      m_tuser
);

  localparam int STORE  = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W = (STORE > 1) ? $clog2(STORE) : 1;
  localparam int QB     = tfdt_pkg::quo_bits(DEPTH_BITS);
  localparam int VW     = QB + 2;
  localparam int EW     = tfdt_pkg::EDGE_W;
  localparam int NW     = tfdt_pkg::NUM_W;
  localparam int DW     = tfdt_pkg::DIV_W;
  localparam int WW     = tfdt_pkg::WEIGHT_W;

  localparam logic signed [VW-1:0] WT_MAX = VW'((64'd1 << (WW - 1)) - 64'd1);
  localparam logic signed [VW-1:0] WT_MIN = -VW'(64'd1 << (WW - 1));
  localparam logic signed [VW-1:0] DZ_MAX = VW'((64'd1 << (DEPTH_BITS - 1)) - 64'd1);
  localparam logic signed [VW-1:0] DZ_MIN = -VW'(64'd1 << (DEPTH_BITS - 1));
  localparam logic [DEPTH_BITS-1:0] DEPTH_LOW = {1'b1, {(DEPTH_BITS - 1){1'b0}}};

  // configuration registers
  logic [tfdt_pkg::VERT_W-1:0]   vertex0, vertex1, vertex2;
  logic [tfdt_pkg::SCREEN_W-1:0] scr_width, scr_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex0    <= '0;
      vertex1    <= '0;
      vertex2    <= '0;
      scr_width  <= tfdt_pkg::SCREEN_W'(256);
      scr_height <= tfdt_pkg::SCREEN_W'(256);
    end else if (cfg_we) begin
      case (cfg_index)
        tfdt_pkg::REG_VERTEX0:       vertex0 <= cfg_data;
        tfdt_pkg::REG_VERTEX1:       vertex1 <= cfg_data;
        tfdt_pkg::REG_VERTEX2:       vertex2 <= cfg_data;
        tfdt_pkg::REG_SCREEN_WIDTH:  scr_width <= cfg_data[tfdt_pkg::SCREEN_W-1:0];
        tfdt_pkg::REG_SCREEN_HEIGHT: scr_height <= cfg_data[tfdt_pkg::SCREEN_W-1:0];
        default: ;
      endcase
    end
  end

  // pixel registers
  logic signed [tfdt_pkg::COORD_W-1:0] px_r, py_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      px_r <= s_tdata[tfdt_pkg::COORD_W-1:0];
      py_r <= s_tdata[2*tfdt_pkg::COORD_W-1:tfdt_pkg::COORD_W];
    end
  end

  // screen clipping against the clamped screen size
  logic [tfdt_pkg::COORD_W-1:0] w_reg, h_reg, w_eff, h_eff;
  logic on_screen;

  assign w_reg = tfdt_pkg::COORD_W'(scr_width);
  assign h_reg = tfdt_pkg::COORD_W'(scr_height);
  assign w_eff = (int'(scr_width) > MAX_WIDTH) ? tfdt_pkg::COORD_W'(MAX_WIDTH) : w_reg;
  assign h_eff = (int'(scr_height) > MAX_HEIGHT) ? tfdt_pkg::COORD_W'(MAX_HEIGHT)
                                                 : h_reg;
  assign on_screen = ~px_r[tfdt_pkg::COORD_W-1] && ~py_r[tfdt_pkg::COORD_W-1]
                  && ({1'b0, px_r[tfdt_pkg::COORD_W-2:0]} < w_eff)
                  && ({1'b0, py_r[tfdt_pkg::COORD_W-2:0]} < h_eff);

  // store address: x + y * width
  logic [23:0]       addr_wide;
  logic [ADDR_W-1:0] pix_addr, addr_r;

  assign addr_wide = 24'(py_r[tfdt_pkg::COORD_W-2:0]) * 24'(w_eff)
                   + 24'(px_r[tfdt_pkg::COORD_W-2:0]);
  assign pix_addr  = addr_wide[ADDR_W-1:0];

  // vertex fields and edge differences
  logic signed [15:0] x0, y0, z0, x1, y1, z1, x2, y2, z2;
  logic signed [16:0] dx1, dy1, dx2, dy2;
  logic signed [17:0] u, v, du, dv;

  assign x0 = vertex0[15:0];
  assign y0 = vertex0[31:16];
  assign z0 = vertex0[47:32];
  assign x1 = vertex1[15:0];
  assign y1 = vertex1[31:16];
  assign z1 = vertex1[47:32];
  assign x2 = vertex2[15:0];
  assign y2 = vertex2[31:16];
  assign z2 = vertex2[47:32];

  assign dx1 = 17'(x1) - 17'(x0);
  assign dy1 = 17'(y1) - 17'(y0);
  assign dx2 = 17'(x2) - 17'(x0);
  assign dy2 = 17'(y2) - 17'(y0);
  assign u   = {3'b000, px_r[tfdt_pkg::COORD_W-2:0], 4'b0000};
  assign v   = {3'b000, py_r[tfdt_pkg::COORD_W-2:0], 4'b0000};
  assign du  = u - 18'(x0);
  assign dv  = v - 18'(y0);

  // shared multiplier operand selection
  logic signed [EW-1:0] d_r, nb_r, ng_r, na_r, na_next;
  logic signed [NW-1:0] acc_r;
  logic signed [tfdt_pkg::MUL_A_W-1:0] mul_a;
  logic signed [tfdt_pkg::MUL_B_W-1:0] mul_b;
  logic signed [tfdt_pkg::PROD_W-1:0]  prod_r;
  logic signed [EW-1:0] prod_e;
  logic signed [NW-1:0] prod_n;

  always_comb begin
    case (cmd.mul_sel)
      tfdt_pkg::MUL_D_P:  begin mul_a = 37'(dx1);  mul_b = 18'(dy2); end
      tfdt_pkg::MUL_D_N:  begin mul_a = 37'(dx2);  mul_b = 18'(dy1); end
      tfdt_pkg::MUL_NB_P: begin mul_a = 37'(du);   mul_b = 18'(dy2); end
      tfdt_pkg::MUL_NB_N: begin mul_a = 37'(dx2);  mul_b = dv;       end
      tfdt_pkg::MUL_NG_P: begin mul_a = 37'(dx1);  mul_b = dv;       end
      tfdt_pkg::MUL_NG_N: begin mul_a = 37'(du);   mul_b = 18'(dy1); end
      tfdt_pkg::MUL_Z0:   begin mul_a = 37'(na_r); mul_b = 18'(z0);  end
      tfdt_pkg::MUL_Z1:   begin mul_a = 37'(nb_r); mul_b = 18'(z1);  end
      tfdt_pkg::MUL_Z2:   begin mul_a = 37'(ng_r); mul_b = 18'(z2);  end
      default:            begin mul_a = '0;        mul_b = '0;       end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) prod_r <= mul_a * mul_b;
  end

  assign prod_e  = EW'(prod_r);
  assign prod_n  = NW'(prod_r);
  assign na_next = d_r - nb_r - ng_r;

  // edge function and depth accumulators
  logic inside_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      d_r      <= '0;
      nb_r     <= '0;
      ng_r     <= '0;
      na_r     <= '0;
      acc_r    <= '0;
      inside_r <= 1'b0;
    end else if (cmd.acc_en) begin
      case (cmd.acc_sel)
        tfdt_pkg::MUL_D_P:  d_r   <= d_r + prod_e;
        tfdt_pkg::MUL_D_N:  d_r   <= d_r - prod_e;
        tfdt_pkg::MUL_NB_P: nb_r  <= nb_r + prod_e;
        tfdt_pkg::MUL_NB_N: nb_r  <= nb_r - prod_e;
        tfdt_pkg::MUL_NG_P: ng_r  <= ng_r + prod_e;
        tfdt_pkg::MUL_NG_N: ng_r  <= ng_r - prod_e;
        default:            acc_r <= acc_r + prod_n;
      endcase
    end else if (cmd.fix_sign) begin
      if (d_r[EW-1]) begin
        d_r  <= -d_r;
        nb_r <= -nb_r;
        ng_r <= -ng_r;
      end
    end else if (cmd.calc_na) begin
      na_r     <= na_next;
      inside_r <= ~na_next[EW-1] & ~nb_r[EW-1] & ~ng_r[EW-1];
    end
  end

  // serial divider set-up: rounded magnitude and overflow check
  logic signed [NW-1:0] num_s;
  logic [NW-1:0] num_mag, num_rnd, num_hi;
  logic [DW-1:0] d_u;
  logic          num_neg, ovf_set;

  assign d_u = d_r[DW-1:0];

  always_comb begin
    case (cmd.div_sel)
      tfdt_pkg::DIV_BETA:  num_s = NW'(nb_r) <<< tfdt_pkg::WEIGHT_FRAC;
      tfdt_pkg::DIV_GAMMA: num_s = NW'(ng_r) <<< tfdt_pkg::WEIGHT_FRAC;
      tfdt_pkg::DIV_DEPTH: num_s = acc_r;
      default:             num_s = '0;
    endcase
  end

  assign num_neg = num_s[NW-1];
  assign num_mag = num_neg ? NW'(-num_s) : NW'(num_s);
  assign num_rnd = num_mag + NW'(d_u >> 1);
  assign num_hi  = num_rnd >> QB;
  assign ovf_set = (num_hi >= NW'(d_u));

  // restoring division, one quotient bit per cycle
  logic [DW-1:0] rem_r;
  logic [QB-1:0] lo_r, q_r;
  logic          neg_r, ovf_r;
  logic [DW:0]   trial, trial_sub;
  logic          ge;

  assign trial     = {rem_r, lo_r[QB-1]};
  assign ge        = (trial >= {1'b0, d_u});
  assign trial_sub = trial - {1'b0, d_u};

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      neg_r <= num_neg;
      ovf_r <= ovf_set;
      rem_r <= num_hi[DW-1:0];
      lo_r  <= num_rnd[QB-1:0];
      q_r   <= '0;
    end else if (cmd.div_step) begin
      rem_r <= ge ? trial_sub[DW-1:0] : trial[DW-1:0];
      lo_r  <= lo_r << 1;
      q_r   <= {q_r[QB-2:0], ge};
    end
  end

  // signed quotient with saturation
  logic signed [VW-1:0] q_s, q_v;
  logic signed [WW-1:0] w_sat;
  logic signed [DEPTH_BITS-1:0] z_sat;

  assign q_s = {2'b00, q_r};
  assign q_v = neg_r ? -q_s : q_s;

  always_comb begin
    if (ovf_r) begin
      w_sat = neg_r ? WW'(WT_MIN) : WW'(WT_MAX);
      z_sat = neg_r ? DEPTH_BITS'(DZ_MIN) : DEPTH_BITS'(DZ_MAX);
    end else begin
      if (q_v > WT_MAX)      w_sat = WW'(WT_MAX);
      else if (q_v < WT_MIN) w_sat = WW'(WT_MIN);
      else                   w_sat = WW'(q_v);
      if (q_v > DZ_MAX)      z_sat = DEPTH_BITS'(DZ_MAX);
      else if (q_v < DZ_MIN) z_sat = DEPTH_BITS'(DZ_MIN);
      else                   z_sat = DEPTH_BITS'(q_v);
    end
  end

  // per pixel results
  logic signed [WW-1:0]         beta_r, gamma_r;
  logic signed [DEPTH_BITS-1:0] depth_r, rd_r;
  logic                         wrote_r, gt;

  assign gt = (depth_r > rd_r);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      beta_r  <= '0;
      gamma_r <= '0;
      depth_r <= '0;
      wrote_r <= 1'b0;
    end else if (cmd.div_store) begin
      case (cmd.div_sel)
        tfdt_pkg::DIV_BETA:  beta_r  <= w_sat;
        tfdt_pkg::DIV_GAMMA: gamma_r <= w_sat;
        tfdt_pkg::DIV_DEPTH: depth_r <= z_sat;
        default: ;
      endcase
    end else if (cmd.depth_test) begin
      wrote_r <= gt;
    end
  end

  // clearing sweep after reset
  logic [ADDR_W-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) clr_addr <= '0;
    else if (cmd.clr_step) clr_addr <= clr_addr + 1'b1;
  end

  // depth store
  logic [DEPTH_BITS-1:0] store [STORE];
  logic                  st_we;
  logic [ADDR_W-1:0]     st_waddr;
  logic [DEPTH_BITS-1:0] st_wdata;

  assign st_we    = cmd.clr_step | (cmd.depth_test & gt);
  assign st_waddr = cmd.clr_step ? clr_addr : addr_r;
  assign st_wdata = cmd.clr_step ? DEPTH_LOW : depth_r;

  always_ff @(posedge clk) begin
    if (st_we) store[st_waddr] <= st_wdata;
    if (cmd.mem_rd) begin
      rd_r   <= store[pix_addr];
      addr_r <= pix_addr;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (cmd.out_load) m_tvalid <= 1'b1;
    else if (m_tready) m_tvalid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      m_tuser <= {wrote_r, inside_r, on_screen};
      m_tdata <= {6'b000000, gamma_r, beta_r, tfdt_pkg::DEPTH_OUT_W'(depth_r)};
    end
  end

  // status to the sequencer
  assign status.clear_done = (clr_addr == ADDR_W'(STORE - 1));
  assign status.on_screen  = on_screen;
  assign status.d_zero     = (d_r == '0);
  assign status.in_tri     = inside_r;
  assign status.out_free   = ~m_tvalid | m_tready;

endmodule

[dv/triangle_fragment_depth_test_checker.sv]
// checker for the triangle fragment depth test: predicts each fragment and compares results
`timescale 1ns / 1ps

module triangle_fragment_depth_test_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [tfdt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tfdt_pkg::VERT_W-1:0]      cfg_data,
  input  logic                             s_tvalid,
  input  logic                             s_tready,
  input  logic [tfdt_pkg::S_TDATA_W-1:0]   s_tdata,
  input  logic                             m_tvalid,
  input  logic                             m_tready,
  input  logic [tfdt_pkg::M_TDATA_W-1:0]   m_tdata,
  input  logic [tfdt_pkg::M_TUSER_W-1:0]   m_tuser,
  output int                               pending,
  output int                               errors
);

  localparam int SCR_MAX_W = 256;
  localparam int SCR_MAX_H = 256;
  localparam longint Z_MIN = -32768;
  localparam longint Z_MAX = 32767;

  typedef struct {
    bit     on_screen;
    bit     inside_res;
    bit     depth_written;
    longint depth;
    longint beta;
    longint gamma;
  } fragment_t;

  logic [tfdt_pkg::VERT_W-1:0]   vert [3];
  logic [tfdt_pkg::SCREEN_W-1:0] scr_w;
  logic [tfdt_pkg::SCREEN_W-1:0] scr_h;
  logic signed [15:0]            z_buffer [SCR_MAX_W*SCR_MAX_H];
  fragment_t                     expected_fragments [$];

  initial begin
    errors = 0;
    pending = 0;
    foreach (z_buffer[i]) z_buffer[i] = 16'sh8000;
  end

  // division rounded to nearest, ties away from zero; den > 0
  function automatic longint round_div(longint num, longint den);
    longint mag;
    mag = (num < 0) ? -num : num;
    mag = (mag + den / 2) / den;
    return (num < 0) ? -mag : mag;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // rasterise one pixel against the current triangle, updating the z buffer
  function automatic fragment_t shade_pixel(longint px, longint py);
    fragment_t f;
    longint w, h, u, v, d, nb, ng, na, idx;
    longint x0, y0, z0, x1, y1, z1, x2, y2, z2;
    f = '{default: 0};
    w = (scr_w > SCR_MAX_W) ? SCR_MAX_W : scr_w;
    h = (scr_h > SCR_MAX_H) ? SCR_MAX_H : scr_h;
    x0 = $signed(vert[0][15:0]); y0 = $signed(vert[0][31:16]); z0 = $signed(vert[0][47:32]);
    x1 = $signed(vert[1][15:0]); y1 = $signed(vert[1][31:16]); z1 = $signed(vert[1][47:32]);
    x2 = $signed(vert[2][15:0]); y2 = $signed(vert[2][31:16]); z2 = $signed(vert[2][47:32]);
    f.on_screen = (px >= 0 && px < w && py >= 0 && py < h);
    if (!f.on_screen) return f;
    u = px * 16;
    v = py * 16;
    d = (x1 - x0) * (y2 - y0) - (x2 - x0) * (y1 - y0);
    if (d == 0) return f;
    nb = (u - x0) * (y2 - y0) - (x2 - x0) * (v - y0);
    ng = (x1 - x0) * (v - y0) - (u - x0) * (y1 - y0);
    if (d < 0) begin
      d = -d;
      nb = -nb;
      ng = -ng;
    end
    na = d - nb - ng;
    f.beta = clip(round_div(nb * 32768, d), -65536, 65535);
    f.gamma = clip(round_div(ng * 32768, d), -65536, 65535);
    if (na >= 0 && nb >= 0 && ng >= 0) begin
      f.inside_res = 1;
      f.depth = clip(round_div(na * z0 + nb * z1 + ng * z2, d), Z_MIN, Z_MAX);
      idx = px + py * w;
      if (f.depth > longint'(z_buffer[idx])) begin
        z_buffer[idx] = 16'(f.depth);
        f.depth_written = 1;
      end
    end
    return f;
  endfunction

  function automatic void check_field(string name, longint want, longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  // track register writes
  always @(posedge clk) begin
    if (rst) begin
      vert[0] <= '0;
      vert[1] <= '0;
      vert[2] <= '0;
      scr_w <= 9'd256;
      scr_h <= 9'd256;
    end else if (cfg_we) begin
      case (cfg_index)
        tfdt_pkg::REG_VERTEX0:       vert[0] <= cfg_data;
        tfdt_pkg::REG_VERTEX1:       vert[1] <= cfg_data;
        tfdt_pkg::REG_VERTEX2:       vert[2] <= cfg_data;
        tfdt_pkg::REG_SCREEN_WIDTH:  scr_w <= cfg_data[tfdt_pkg::SCREEN_W-1:0];
        tfdt_pkg::REG_SCREEN_HEIGHT: scr_h <= cfg_data[tfdt_pkg::SCREEN_W-1:0];
        default: ;
      endcase
    end
  end

  // predict on each pixel transfer, compare on each result transfer
  always @(posedge clk) begin
    fragment_t want;
    if (!rst && s_tvalid && s_tready)
      expected_fragments.push_back(shade_pixel($signed(s_tdata[11:0]),
                                               $signed(s_tdata[23:12])));
    if (!rst && m_tvalid && m_tready) begin
      if (expected_fragments.size() == 0) begin
        $error("result transfer with no fragment outstanding");
        errors++;
      end else begin
        want = expected_fragments.pop_front();
        check_field("on_screen", want.on_screen, m_tuser[0]);
        check_field("inside_res", want.inside_res, m_tuser[1]);
        check_field("depth_written", want.depth_written, m_tuser[2]);
        check_field("depth", want.depth, $signed(m_tdata[15:0]));
        check_field("weight_beta", want.beta, $signed(m_tdata[32:16]));
        check_field("weight_gamma", want.gamma, $signed(m_tdata[49:33]));
      end
    end
    pending = expected_fragments.size();
  end

endmodule

[dv/triangle_fragment_depth_test_test.sv]
// testbench top of the triangle fragment depth test: stimulus and verdict
`timescale 1ns / 1ps

module triangle_fragment_depth_test_test;

  localparam int CYCLE_LIMIT = 3000000;

  logic                           clk = 0;
  logic                           rst = 1;
  logic                           cfg_we = 0;
  logic [tfdt_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [tfdt_pkg::VERT_W-1:0]    cfg_data = '0;
  logic                           s_tvalid = 0;
  logic                           s_tready;
  logic [tfdt_pkg::S_TDATA_W-1:0] s_tdata = '0;
  logic                           m_tvalid;
  logic                           m_tready = 0;
  logic [tfdt_pkg::M_TDATA_W-1:0] m_tdata;
  logic [tfdt_pkg::M_TUSER_W-1:0] m_tuser;
  int                             pending;
  int                             errors;
  int                             send_idle_pct = 0;
  int                             recv_stall_pct = 0;
  int                             cycles = 0;
  // triangle bounding box in pixels, for aiming random pixels
  int                             box_x0, box_x1, box_y0, box_y1;

  triangle_fragment_depth_test i_dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  triangle_fragment_depth_test_checker i_checker (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .pending(pending), .errors(errors)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // result side back-pressure
  always @(posedge clk)
    m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("triangle_fragment_depth_test_test: done, errors");
      $finish;
    end
  end

  function automatic logic [tfdt_pkg::VERT_W-1:0] vertex_word(int x, int y, int z);
    logic [15:0] xs, ys, zs;
    xs = 16'(x);
    ys = 16'(y);
    zs = 16'(z);
    return {zs, ys, xs};
  endfunction

  // one pixel transfer, with random idle cycles ahead of it
  task automatic send_pixel(int x, int y);
    logic [11:0] xs, ys;
    xs = 12'(x);
    ys = 12'(y);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    s_tvalid <= 1;
    s_tdata <= {ys, xs};
    forever begin
      @(negedge clk);
      if (s_tready) break;
    end
    @(posedge clk);
  endtask

  // wait for every outstanding fragment, then leave the block a short rest
  task automatic drain;
    s_tvalid <= 0;
    do @(negedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic configure(logic [tfdt_pkg::VERT_W-1:0] v0, logic [tfdt_pkg::VERT_W-1:0] v1,
                           logic [tfdt_pkg::VERT_W-1:0] v2, int w, int h);
    logic [tfdt_pkg::VERT_W-1:0] vals [5];
    logic [tfdt_pkg::CFG_IDX_W-1:0] regs [5];
    int xs [3], ys [3];
    vals = '{v0, v1, v2, tfdt_pkg::VERT_W'(w), tfdt_pkg::VERT_W'(h)};
    regs = '{tfdt_pkg::REG_VERTEX0, tfdt_pkg::REG_VERTEX1, tfdt_pkg::REG_VERTEX2,
             tfdt_pkg::REG_SCREEN_WIDTH, tfdt_pkg::REG_SCREEN_HEIGHT};
    drain();
    for (int i = 0; i < 5; i++) begin
      cfg_we <= 1;
      cfg_index <= regs[i];
      cfg_data <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 0;
    xs = '{$signed(v0[15:0]) >>> 4, $signed(v1[15:0]) >>> 4, $signed(v2[15:0]) >>> 4};
    ys = '{$signed(v0[31:16]) >>> 4, $signed(v1[31:16]) >>> 4, $signed(v2[31:16]) >>> 4};
    box_x0 = xs[0]; box_x1 = xs[0]; box_y0 = ys[0]; box_y1 = ys[0];
    for (int i = 1; i < 3; i++) begin
      if (xs[i] < box_x0) box_x0 = xs[i];
      if (xs[i] > box_x1) box_x1 = xs[i];
      if (ys[i] < box_y0) box_y0 = ys[i];
      if (ys[i] > box_y1) box_y1 = ys[i];
    end
  endtask

  function automatic logic [tfdt_pkg::VERT_W-1:0] random_vertex(int bx, int by, int span);
    return vertex_word(bx * 16 + $urandom_range(0, span * 16) - 8,
                       by * 16 + $urandom_range(0, span * 16) - 8,
                       $urandom_range(0, 65535));
  endfunction

  initial begin
    int sw, sh, bx, by, span;
    logic [tfdt_pkg::VERT_W-1:0] va, vb, vc;
    repeat (9) @(posedge clk);
    rst <= 0;

    // directed: large triangle over the default screen
    va = vertex_word(0, 0, 100);
    vb = vertex_word(255 * 16, 0, -200);
    vc = vertex_word(0, 255 * 16, 32767);
    configure(va, vb, vc, 256, 256);
    send_pixel(0, 0);
    send_pixel(0, 0);          // equal depth, no store write
    send_pixel(100, 100);
    send_pixel(255, 0);
    send_pixel(0, 255);
    send_pixel(128, 128);      // just outside the hypotenuse
    send_pixel(255, 255);
    send_pixel(-1, 0);
    send_pixel(0, -1);
    send_pixel(256, 0);
    send_pixel(0, 256);
    send_pixel(-2048, -2048);
    send_pixel(2047, 2047);
    send_pixel(2047, -2048);
    // opposite winding
    configure(va, vc, vb, 256, 256);
    send_pixel(10, 10);
    send_pixel(100, 100);
    // zero area
    configure(va, vb, vb, 256, 256);
    send_pixel(5, 5);
    // zero width, then a one-pixel screen
    configure(va, vb, vc, 0, 256);
    send_pixel(0, 0);
    configure(va, vb, vc, 1, 1);
    send_pixel(0, 0);
    send_pixel(1, 0);
    // oversized screen registers are clamped
    configure(va, vb, vc, 511, 511);
    send_pixel(255, 255);
    send_pixel(256, 3);
    send_pixel(3, 256);
    // writes to indexes beyond the register list are ignored
    drain();
    for (int i = 5; i < 8; i++) begin
      cfg_we <= 1;
      cfg_index <= tfdt_pkg::CFG_IDX_W'(i);
      cfg_data <= {tfdt_pkg::VERT_W{1'b1}};
      @(posedge clk);
    end
    cfg_we <= 0;
    send_pixel(50, 50);

    // random phases across the idling patterns
    for (int p = 0; p < 12; p++) begin
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 73; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 73; end
        default: begin send_idle_pct = 33; recv_stall_pct = 33; end
      endcase
      sw = $urandom_range(0, 99);
      sw = (sw < 5) ? 0 : ((sw < 15) ? $urandom_range(257, 511) : $urandom_range(1, 256));
      sh = $urandom_range(0, 99);
      sh = (sh < 10) ? $urandom_range(257, 511) : $urandom_range(1, 256);
      span = (p == 5) ? 255 : $urandom_range(2, 40);
      bx = $urandom_range(0, 255);
      by = $urandom_range(0, 255);
      if (p == 7) begin
        // arbitrary bit patterns in every vertex field
        va = tfdt_pkg::VERT_W'({$urandom(), $urandom()});
        vb = tfdt_pkg::VERT_W'({$urandom(), $urandom()});
        vc = tfdt_pkg::VERT_W'({$urandom(), $urandom()});
      end else begin
        va = random_vertex(bx, by, span);
        vb = random_vertex(bx, by, span);
        vc = random_vertex(bx, by, span);
      end
      configure(va, vb, vc, sw, sh);
      for (int n = 0; n < 46; n++) begin
        if ($urandom_range(0, 99) < 80 && box_x1 - box_x0 < 3000 && box_y1 - box_y0 < 3000)
          send_pixel($urandom_range(0, box_x1 - box_x0 + 2) + box_x0 - 1,
                     $urandom_range(0, box_y1 - box_y0 + 2) + box_y0 - 1);
        else
          send_pixel($signed(12'($urandom())), $signed(12'($urandom())));
      end
    end

    drain();
    repeat (100) @(posedge clk);
    if (errors == 0)
      $display("triangle_fragment_depth_test_test: done, clean");
    else
      $display("triangle_fragment_depth_test_test: done, errors");
    $finish;
  end

endmodule

[filelist.f]
rtl/core/tfdt_pkg.sv
rtl/core/tfdt_ctrl.sv
rtl/core/tfdt_dpath.sv
rtl/core/triangle_fragment_depth_test.sv
dv/triangle_fragment_depth_test_checker.sv
dv/triangle_fragment_depth_test_test.sv
